@@ sv/hbsc_pkg.sv @@
// Package with the constants and types shared by the HDLC bit-stuffing codec.
`timescale 1ns / 1ps
package hbsc_pkg;

	localparam logic [7:0] HDLC_FLAG = 8'h7E;
	localparam logic [2:0] STUFF_RUN = 3'd5;
	localparam logic [2:0] RUN_MAX   = 3'd7;
	localparam logic [2:0] FLAG_LAST = 3'd7;
	localparam logic [4:0] FLAG_LEN  = 5'd8;
	localparam logic [4:0] MIN_FRAME = 5'd16;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// Segment positions in a beat plan, emitted lowest first.
	localparam int SEG_PRE   = 0;
	localparam int SEG_DATA  = 1;
	localparam int SEG_STUFF = 2;
	localparam int SEG_POST  = 3;
	localparam int SEG_N     = 4;

	typedef logic [SEG_N-1:0] hbsc_seg_t;

	// What one input item releases on the output side.
	typedef struct packed {
		hbsc_seg_t mask;
		logic      data_val;
		logic      post_marker;
		logic      short_frame;
	} hbsc_plan_t;

endpackage

@@ sv/hbsc_ifs.sv @@
// Channel interfaces of the HDLC bit-stuffing codec.
`timescale 1ns / 1ps
interface hbsc_in_if;
	logic valid;
	logic ready;
	logic data_bit;
	logic frame_start;
	logic frame_end;
	modport source (output valid, output data_bit, output frame_start, output frame_end,
		input ready);
	modport sink (input valid, input data_bit, input frame_start, input frame_end,
		output ready);
endinterface

interface hbsc_out_if;
	logic valid;
	logic ready;
	logic out_bit;
	logic has_bit;
	logic frame_done;
	logic short_frame;
	logic run_last;
	modport source (output valid, output out_bit, output has_bit, output frame_done,
		output short_frame, output run_last, input ready);
	modport sink (input valid, input out_bit, input has_bit, input frame_done,
		input short_frame, input run_last, output ready);
endinterface

interface hbsc_cfg_if;
	logic valid;
	logic ready;
	logic direction;
	modport source (output valid, output direction, input ready);
	modport sink (input valid, input direction, output ready);
endinterface

@@ sv/hbsc_step.sv @@
// Frame state of the codec and the beat plan that each input item produces.
`timescale 1ns / 1ps
module hbsc_step import hbsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       direction,
	input  logic       accept,
	input  logic       data_bit,
	input  logic       frame_start,
	input  logic       frame_end,
	output hbsc_plan_t plan
);

	logic       in_frame_q;
	logic [2:0] ones_run_q;
	logic [4:0] count_q;
	logic [7:0] hold_q;

	logic       in_frame_d;
	logic [2:0] ones_run_d;
	logic [4:0] count_d;
	logic [7:0] hold_d;

	logic [2:0] run0;
	logic [2:0] run_inc;
	logic [4:0] cnt0;
	logic [7:0] hold0;
	logic       rel_bit;

	always_comb begin
		run0 = frame_start ? 3'd0 : ones_run_q;
		cnt0 = frame_start ? 5'd0 : count_q;
		hold0 = frame_start ? 8'd0 : hold_q;
		run_inc = run0 + 3'd1;
		rel_bit = hold0[7];

		plan = '0;
		in_frame_d = in_frame_q;
		ones_run_d = ones_run_q;
		count_d = count_q;
		hold_d = hold_q;

		if (frame_start || in_frame_q) begin
			in_frame_d = 1'b1;
			ones_run_d = run0;
			count_d = cnt0;
			hold_d = hold0;
			if (direction == DIR_ENCODE) begin
				plan.mask[SEG_PRE] = frame_start;
				plan.mask[SEG_DATA] = 1'b1;
				plan.data_val = data_bit;
				if (data_bit) begin
					if (run_inc >= STUFF_RUN) begin
						plan.mask[SEG_STUFF] = 1'b1;
						ones_run_d = 3'd0;
					end else begin
						ones_run_d = run_inc;
					end
				end else begin
					ones_run_d = 3'd0;
				end
				if (frame_end) begin
					plan.mask[SEG_POST] = 1'b1;
					in_frame_d = 1'b0;
					ones_run_d = 3'd0;
				end
			end else begin
				if (cnt0 >= MIN_FRAME) begin
					// A zero right after exactly five ones is a stuffed bit.
					if (run0 == STUFF_RUN && !rel_bit) begin
						ones_run_d = 3'd0;
					end else begin
						plan.mask[SEG_DATA] = 1'b1;
						plan.data_val = rel_bit;
						if (!rel_bit) begin
							ones_run_d = 3'd0;
						end else if (run0 < RUN_MAX) begin
							ones_run_d = run_inc;
						end
					end
				end
				if (cnt0 >= FLAG_LEN) begin
					hold_d = {hold0[6:0], data_bit};
				end
				count_d = (cnt0 >= MIN_FRAME) ? MIN_FRAME : cnt0 + 5'd1;
				if (frame_end) begin
					plan.mask[SEG_POST] = 1'b1;
					plan.post_marker = 1'b1;
					plan.short_frame = (count_d < MIN_FRAME);
					in_frame_d = 1'b0;
					ones_run_d = 3'd0;
					count_d = 5'd0;
					hold_d = 8'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			ones_run_q <= 3'd0;
			count_q <= 5'd0;
			hold_q <= 8'd0;
		end else if (accept) begin
			in_frame_q <= in_frame_d;
			ones_run_q <= ones_run_d;
			count_q <= count_d;
			hold_q <= hold_d;
		end
	end

endmodule

@@ sv/hbsc_emit.sv @@
// Plan register and beat sequencer that drives the output register.
`timescale 1ns / 1ps
module hbsc_emit import hbsc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  hbsc_plan_t   plan,
	output logic         in_ready,
	hbsc_out_if.source   res
);

	hbsc_plan_t plan_s1;
	hbsc_seg_t  rem_s1;
	logic [2:0] idx_s1;

	logic       out_valid_q;
	logic       out_bit_q;
	logic       has_bit_q;
	logic       frame_done_q;
	logic       short_frame_q;
	logic       run_last_q;

	hbsc_seg_t  cur;
	hbsc_seg_t  rest;
	logic       busy;
	logic       advance;
	logic       flag_seg;
	logic       seg_end;
	logic       last_beat;
	logic       flag_bit;
	logic       r_bit;
	logic       r_has;
	logic       r_done;
	logic       r_short;

	always_comb begin
		busy = |rem_s1;
		// Lowest pending segment goes first.
		cur = rem_s1 & (~rem_s1 + hbsc_seg_t'(1));
		rest = rem_s1 & ~cur;
		flag_seg = cur[SEG_PRE] || (cur[SEG_POST] && !plan_s1.post_marker);
		seg_end = !flag_seg || (idx_s1 == FLAG_LAST);
		last_beat = seg_end && (rest == '0);
		advance = busy && (!out_valid_q || res.ready);
		in_ready = !busy || (advance && last_beat);
		flag_bit = HDLC_FLAG[FLAG_LAST - idx_s1];

		r_bit = 1'b0;
		r_has = 1'b1;
		r_done = 1'b0;
		r_short = 1'b0;
		if (cur[SEG_PRE]) begin
			r_bit = flag_bit;
		end else if (cur[SEG_DATA]) begin
			r_bit = plan_s1.data_val;
		end else if (cur[SEG_POST]) begin
			if (plan_s1.post_marker) begin
				r_has = 1'b0;
				r_done = 1'b1;
				r_short = plan_s1.short_frame;
			end else begin
				r_bit = flag_bit;
				r_done = (idx_s1 == FLAG_LAST);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s1 <= '0;
			idx_s1 <= 3'd0;
		end else if (load) begin
			rem_s1 <= plan.mask;
			idx_s1 <= 3'd0;
		end else if (advance) begin
			if (seg_end) begin
				rem_s1 <= rest;
				idx_s1 <= 3'd0;
			end else begin
				idx_s1 <= idx_s1 + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			plan_s1 <= plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_bit_q <= r_bit;
			has_bit_q <= r_has;
			frame_done_q <= r_done;
			short_frame_q <= r_short;
			run_last_q <= last_beat;
		end
	end

	assign res.valid = out_valid_q;
	assign res.out_bit = out_bit_q;
	assign res.has_bit = has_bit_q;
	assign res.frame_done = frame_done_q;
	assign res.short_frame = short_frame_q;
	assign res.run_last = run_last_q;

endmodule

@@ sv/hdlc_bit_stuff_codec.sv @@
// Top level of the HDLC zero-bit stuffing codec.
//
// bit_in carries one line bit per beat with frame_start and frame_end marks.
// bit_out carries the results; run_last marks the last result of an input
// beat, frame_done the last result of a frame. cfg writes the direction
// register (0 stuffs and adds flags, 1 strips flags and destuffs); write it
// only while the codec is idle.
// An accepted beat updates the frame state at once and leaves a plan of its
// results in the plan register; the sequencer sends one result per cycle to
// the output register while the receiver takes them. The next beat is taken
// in the same cycle as the last result of a beat enters the output register.
// In encode a frame's first beat releases the opening flag and the data bit,
// its last the data bit, a stuffed zero if one follows and the closing flag,
// and a one-bit frame's single beat both eight-bit flags. Beats outside a
// frame and short decode beats that do not end the frame produce no result.
// Reset clears the frame state, the direction (encode) and any pending
// results. When the receiver stalls, the output register holds its result
// and bit_in.ready drops once the plan register is also full.
`timescale 1ns / 1ps
module hdlc_bit_stuff_codec import hbsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	hbsc_in_if.sink     bit_in,
	hbsc_out_if.source  bit_out,
	hbsc_cfg_if.sink    cfg
);

	logic       direction_q;
	logic       accept;
	logic       in_ready;
	hbsc_plan_t plan;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_ENCODE;
		end else if (cfg.valid) begin
			direction_q <= cfg.direction;
		end
	end

	assign bit_in.ready = in_ready;
	assign accept = bit_in.valid && in_ready;

	hbsc_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.direction   (direction_q),
		.accept      (accept),
		.data_bit    (bit_in.data_bit),
		.frame_start (bit_in.frame_start),
		.frame_end   (bit_in.frame_end),
		.plan        (plan)
	);

	hbsc_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && (plan.mask != '0)),
		.plan     (plan),
		.in_ready (in_ready),
		.res      (bit_out)
	);

endmodule
